[src/pfa_pkg.sv]
// Package for the partition fit allocator: sizes, field widths, payload structs,
// command and fit-mode codes and the sequencer state type.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package pfa_pkg;

	localparam int PART_COUNT = 16;
	localparam int SIZE_BITS  = 16;
	localparam int PIDX_W     = (PART_COUNT > 1) ? $clog2(PART_COUNT) : 1;

	localparam int CMD_W   = 2;
	localparam int INDEX_W = 4;
	localparam int AMT_W   = 16;
	localparam int MODE_W  = 2;

	localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RESTORE = 2'd2;

	localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
	localparam logic [MODE_W-1:0] FIT_NEXT  = 2'd1;
	localparam logic [MODE_W-1:0] FIT_BEST  = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [INDEX_W-1:0] part_index;
		logic [AMT_W-1:0]   amount;
	} in_item_t;

	typedef struct packed {
		logic               granted;
		logic [INDEX_W-1:0] chosen_part;
		logic [AMT_W-1:0]   left_after;
	} out_item_t;

	typedef enum logic [1:0] {
		KIND_LOAD,
		KIND_ALLOC,
		KIND_RESTORE,
		KIND_NONE
	} cmd_kind_t;

	// A classified request as it waits between the front and the back.
	typedef struct packed {
		cmd_kind_t              kind;
		logic                   idx_ok;
		logic [PIDX_W-1:0]      idx;
		logic [SIZE_BITS-1:0]   amount;
	} cmd_entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESTORE,
		ST_REPLY
	} seq_state_t;

endpackage

[src/pfa_front.sv]
// Front of the partition fit allocator: accepts requests, decodes the command
// and holds them in a two-entry queue for the back. Depends on pfa_pkg.
`timescale 1ns / 1ps

module pfa_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  pfa_pkg::in_item_t  item,
	output logic               q_valid,
	output pfa_pkg::cmd_entry_t q_entry,
	input  logic               q_take
);
	import pfa_pkg::*;

	cmd_entry_t entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	cmd_entry_t decoded;
	logic       do_push;
	logic       do_pop;

	always_comb begin
		case (item.cmd)
			CMD_LOAD:    decoded.kind = KIND_LOAD;
			CMD_ALLOC:   decoded.kind = KIND_ALLOC;
			CMD_RESTORE: decoded.kind = KIND_RESTORE;
			default:     decoded.kind = KIND_NONE;
		endcase
		decoded.idx_ok = (32'(item.part_index) < PART_COUNT);
		decoded.idx    = PIDX_W'(item.part_index);
		decoded.amount = SIZE_BITS'(item.amount);
	end

	assign full    = (count_q == 2'd2);
	assign q_valid = (count_q != 2'd0);
	assign q_entry = entry_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = q_take && q_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= decoded;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[src/pfa_back.sv]
// Back of the partition fit allocator: holds the partition table, scans it one
// partition per cycle for a fit, sweeps it for a restore and keeps the result
// register. Depends on pfa_pkg.
`timescale 1ns / 1ps

module pfa_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  pfa_pkg::cmd_entry_t q_entry,
	output logic                q_take,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [pfa_pkg::MODE_W-1:0] cfg_data,
	output logic                empty,
	input  logic                pop,
	output pfa_pkg::out_item_t  result
);
	import pfa_pkg::*;

	seq_state_t           state_q;
	seq_state_t           state_d;
	logic [MODE_W-1:0]    fit_mode_q;
	logic [SIZE_BITS-1:0] orig_q [PART_COUNT];
	logic [SIZE_BITS-1:0] rem_q  [PART_COUNT];
	logic [PIDX_W-1:0]    next_start_q;
	logic [PIDX_W-1:0]    cnt_q;
	logic [SIZE_BITS-1:0] need_q;
	logic                 found_q;
	logic [PIDX_W-1:0]    best_idx_q;
	logic [SIZE_BITS-1:0] best_val_q;
	out_item_t            res_q;
	out_item_t            out_q;
	logic                 out_valid_q;

	logic                 best_mode;
	logic [PIDX_W-1:0]    scan_base;
	logic [PIDX_W:0]      scan_sum;
	logic [PIDX_W-1:0]    k;
	logic [SIZE_BITS-1:0] rem_k;
	logic                 hit;
	logic                 is_last;
	logic                 better;
	logic                 fin_found;
	logic [PIDX_W-1:0]    fin_idx;
	logic [SIZE_BITS-1:0] fin_val;
	logic [SIZE_BITS-1:0] left;
	logic                 scan_done;
	logic [PIDX_W-1:0]    k_next;
	logic                 reply_fire;

	assign cfg_ready = 1'b1;
	assign empty     = !out_valid_q;
	assign result    = out_q;

	// Scan position: next fit starts from the saved pointer and wraps round.
	always_comb begin
		best_mode = (fit_mode_q == FIT_BEST);
		scan_base = (fit_mode_q == FIT_NEXT) ? next_start_q : '0;
		scan_sum  = {1'b0, scan_base} + {1'b0, cnt_q};
		if (scan_sum >= (PIDX_W+1)'(PART_COUNT)) begin
			k = PIDX_W'(scan_sum - (PIDX_W+1)'(PART_COUNT));
		end else begin
			k = PIDX_W'(scan_sum);
		end
		rem_k   = rem_q[k];
		hit     = (rem_k >= need_q);
		is_last = (cnt_q == PIDX_W'(PART_COUNT - 1));
		better  = hit && (!found_q || (rem_k < best_val_q));
		if (best_mode) begin
			fin_found = found_q || hit;
			fin_idx   = better ? k : best_idx_q;
			fin_val   = better ? rem_k : best_val_q;
			scan_done = is_last;
		end else begin
			fin_found = hit;
			fin_idx   = k;
			fin_val   = rem_k;
			scan_done = hit || is_last;
		end
		left   = fin_val - need_q;
		k_next = (k == PIDX_W'(PART_COUNT - 1)) ? '0 : k + PIDX_W'(1);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					case (q_entry.kind)
						KIND_ALLOC:   state_d = ST_SCAN;
						KIND_RESTORE: state_d = ST_RESTORE;
						default:      state_d = ST_REPLY;
					endcase
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					state_d = ST_REPLY;
				end
			end
			ST_RESTORE: begin
				if (is_last) begin
					state_d = ST_REPLY;
				end
			end
			ST_REPLY: begin
				if (!out_valid_q || pop) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		q_take     = (state_q == ST_IDLE) && q_valid;
		reply_fire = (state_q == ST_REPLY) && (!out_valid_q || pop);
	end

	always_ff @(posedge clk) begin
		if (q_take) begin
			need_q <= q_entry.amount;
		end
		if (state_q == ST_SCAN && best_mode && better) begin
			best_idx_q <= k;
			best_val_q <= rem_k;
		end
		if (reply_fire) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			fit_mode_q   <= FIT_FIRST;
			next_start_q <= '0;
			cnt_q        <= '0;
			found_q      <= 1'b0;
			out_valid_q  <= 1'b0;
			res_q        <= '0;
			for (int i = 0; i < PART_COUNT; i++) begin
				orig_q[i] <= '0;
				rem_q[i]  <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				fit_mode_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_take) begin
						cnt_q   <= '0;
						found_q <= 1'b0;
						res_q   <= '0;
						if (q_entry.kind == KIND_LOAD && q_entry.idx_ok) begin
							orig_q[q_entry.idx] <= q_entry.amount;
							rem_q[q_entry.idx]  <= q_entry.amount;
						end
					end
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + PIDX_W'(1);
					if (best_mode && better) begin
						found_q <= 1'b1;
					end
					if (scan_done && fin_found) begin
						rem_q[fin_idx]    <= left;
						res_q.granted     <= 1'b1;
						res_q.chosen_part <= INDEX_W'(fin_idx);
						res_q.left_after  <= AMT_W'(left);
						if (fit_mode_q == FIT_NEXT) begin
							next_start_q <= k_next;
						end
					end
				end
				ST_RESTORE: begin
					rem_q[cnt_q] <= orig_q[cnt_q];
					cnt_q        <= cnt_q + PIDX_W'(1);
					if (is_last) begin
						next_start_q <= '0;
					end
				end
				default: begin
				end
			endcase
			if (reply_fire) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[src/partition_fit_allocator.sv]
// Top level of the partition fit allocator: joins the request front to the
// table sequencer at the back. Depends on pfa_pkg, pfa_front and pfa_back.
//
//  Channel   Signals                      Moves
//  request   push, full, item             command, part_index, amount
//  result    empty, pop, result           granted, chosen_part, left_after
//  config    cfg_valid, cfg_ready, cfg_data   fit_mode
//
// A load or an unused command goes from idle straight to the reply state;
// an allocation scans one partition per cycle, at most the whole table;
// a restore sweeps the whole table.
// Reset clears the table, the next-fit pointer and the fit mode at once.
// Two requests queue at the front while the back is busy or its result waits.
`timescale 1ns / 1ps

module partition_fit_allocator (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  pfa_pkg::in_item_t          item,
	output logic                       empty,
	input  logic                       pop,
	output pfa_pkg::out_item_t         result,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [pfa_pkg::MODE_W-1:0] cfg_data
);
	import pfa_pkg::*;

	logic       q_valid;
	logic       q_take;
	cmd_entry_t q_entry;

	pfa_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.q_valid (q_valid),
		.q_entry (q_entry),
		.q_take  (q_take)
	);

	pfa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_entry   (q_entry),
		.q_take    (q_take),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

[tb/tb_partition_fit_allocator.sv]
// Self-checking bench for the partition fit allocator: a scoreboard class predicts
// each request's grant from its own copy of the partition table, tasks drive the block.
// Depends on pfa_pkg and partition_fit_allocator.
`timescale 1ns / 1ps

module tb_partition_fit_allocator;
	import pfa_pkg::*;

	localparam logic [CMD_W-1:0]  CMD_SPARE = 2'd3;
	localparam logic [MODE_W-1:0] FIT_SPARE = 2'd3;
	localparam int SETTLE_CYCLES = PART_COUNT + 4;

	class alloc_scoreboard;
		logic [SIZE_BITS-1:0] orig_size[PART_COUNT];
		logic [SIZE_BITS-1:0] rem_size[PART_COUNT];
		logic [INDEX_W-1:0]   next_start;
		logic [MODE_W-1:0]    mode;
		out_item_t            expected_grants[$];
		int errors;
		int requests;
		int grants;
		int refusals;

		function new();
			foreach (orig_size[i]) begin
				orig_size[i] = '0;
				rem_size[i] = '0;
			end
			next_start = '0;
			mode = FIT_FIRST;
			errors = 0;
			requests = 0;
			grants = 0;
			refusals = 0;
		endfunction

		function void set_mode(logic [MODE_W-1:0] m);
			mode = m;
		endfunction

		function int pending();
			return expected_grants.size();
		endfunction

		// Works out the result of an accepted request and updates the table.
		function void note_request(in_item_t rq);
			out_item_t exp;
			logic [INDEX_W-1:0] k;
			logic found;
			exp = '0;
			k = '0;
			found = 1'b0;
			requests++;
			case (rq.cmd)
				CMD_LOAD: begin
					orig_size[rq.part_index] = rq.amount;
					rem_size[rq.part_index] = rq.amount;
				end
				CMD_ALLOC: begin
					if (mode == FIT_NEXT) begin
						k = next_start;
						for (int i = 0; i < PART_COUNT; i++) begin
							if (!found) begin
								if (rem_size[k] >= rq.amount)
									found = 1'b1;
								else
									k = k + 1'b1;
							end
						end
					end else if (mode == FIT_BEST) begin
						for (int i = 0; i < PART_COUNT; i++) begin
							if (rem_size[i] >= rq.amount && (!found || rem_size[i] < rem_size[k])) begin
								k = INDEX_W'(i);
								found = 1'b1;
							end
						end
					end else begin
						// First fit, which the spare mode code also falls back to.
						for (int i = 0; i < PART_COUNT; i++) begin
							if (!found && rem_size[i] >= rq.amount) begin
								k = INDEX_W'(i);
								found = 1'b1;
							end
						end
					end
					if (found) begin
						rem_size[k] = rem_size[k] - rq.amount;
						if (mode == FIT_NEXT)
							next_start = k + 1'b1;
						exp.granted = 1'b1;
						exp.chosen_part = k;
						exp.left_after = rem_size[k];
						grants++;
					end else begin
						refusals++;
					end
				end
				CMD_RESTORE: begin
					foreach (rem_size[i])
						rem_size[i] = orig_size[i];
					next_start = '0;
				end
				default: ;
			endcase
			expected_grants.push_back(exp);
		endfunction

		function void check_result(out_item_t got);
			out_item_t exp;
			if (expected_grants.size() == 0) begin
				$error("result with nothing outstanding: %p", got);
				errors++;
				return;
			end
			exp = expected_grants.pop_front();
			if (got.granted !== exp.granted) begin
				$error("granted: expected %0d, got %0d", exp.granted, got.granted);
				errors++;
			end
			if (got.chosen_part !== exp.chosen_part) begin
				$error("chosen_part: expected %0d, got %0d", exp.chosen_part, got.chosen_part);
				errors++;
			end
			if (got.left_after !== exp.left_after) begin
				$error("left_after: expected %0d, got %0d", exp.left_after, got.left_after);
				errors++;
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              push;
	logic              full;
	in_item_t          item;
	logic              empty;
	logic              pop;
	out_item_t         result;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [MODE_W-1:0] cfg_data;
	logic              steady;

	alloc_scoreboard sb = new();

	partition_fit_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		pop = 1'b0;
	end

	always @(negedge clk) begin
		if (arst_n)
			pop <= steady || ($urandom_range(99) >= 20);
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			sb.check_result(result);
	end

	task automatic send_request(logic [CMD_W-1:0] cmd, logic [INDEX_W-1:0] idx,
			logic [AMT_W-1:0] amt);
		in_item_t rq;
		int gaps;
		rq.cmd = cmd;
		rq.part_index = idx;
		rq.amount = amt;
		gaps = (steady || $urandom_range(99) >= 20) ? 0 : $urandom_range(1, 4);
		repeat (gaps) begin
			@(negedge clk);
			push <= 1'b0;
		end
		@(negedge clk);
		push <= 1'b1;
		item <= rq;
		forever begin
			@(posedge clk);
			if (!full)
				break;
		end
		sb.note_request(rq);
	endtask

	// Drops push, waits for every outstanding result and lets the back settle.
	task automatic drain_results();
		@(negedge clk);
		push <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_fit_mode(logic [MODE_W-1:0] m);
		drain_results();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= m;
		forever begin
			@(posedge clk);
			if (cfg_ready)
				break;
		end
		sb.set_mode(m);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Mostly loads and allocations sized against the current table, so that
	// partitions fill up, run dry and get restored; the unused command is noise.
	task automatic run_mixed(int count);
		int done;
		int r;
		int p;
		logic [AMT_W-1:0] amt;
		done = 0;
		while (done < count) begin
			r = $urandom_range(99);
			p = $urandom_range(PART_COUNT - 1);
			if (r < 22) begin
				case ($urandom_range(3))
					0: amt = AMT_W'($urandom_range(65535));
					1: amt = '0;
					default: amt = AMT_W'($urandom_range(400));
				endcase
				send_request(CMD_LOAD, INDEX_W'($urandom_range(15)), amt);
				done++;
			end else if (r < 82) begin
				case ($urandom_range(9))
					0, 1, 2: amt = AMT_W'($urandom_range(64));
					3, 4: amt = sb.rem_size[p];
					5: amt = (sb.rem_size[p] > 20) ?
						sb.rem_size[p] - AMT_W'($urandom_range(20)) : '0;
					6: amt = sb.rem_size[p] + 1'b1;
					7: amt = '0;
					default: amt = AMT_W'($urandom_range(65535));
				endcase
				send_request(CMD_ALLOC, INDEX_W'($urandom_range(15)), amt);
				done++;
			end else if (r < 90) begin
				send_request(CMD_RESTORE, INDEX_W'($urandom_range(15)),
					AMT_W'($urandom_range(65535)));
				done++;
			end else if (r < 94) begin
				send_request(CMD_SPARE, INDEX_W'($urandom_range(15)),
					AMT_W'($urandom_range(65535)));
			end else begin
				send_request(CMD_ALLOC, INDEX_W'($urandom_range(15)),
					AMT_W'($urandom_range(8)));
				done++;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		steady = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: empty table, zero jobs, full-scale sizes, the unused command.
		send_request(CMD_ALLOC, 4'd0, 16'd0);
		send_request(CMD_ALLOC, 4'd15, 16'd1);
		send_request(CMD_LOAD, 4'd0, 16'hFFFF);
		send_request(CMD_LOAD, 4'd15, 16'd1);
		send_request(CMD_LOAD, 4'd7, 16'hFFFF);
		send_request(CMD_ALLOC, 4'd0, 16'hFFFF);
		send_request(CMD_ALLOC, 4'd0, 16'd1);
		send_request(CMD_ALLOC, 4'd0, 16'hFFFF);
		send_request(CMD_SPARE, 4'd15, 16'hFFFF);
		send_request(CMD_RESTORE, 4'd0, 16'd0);
		send_request(CMD_LOAD, 4'd3, 16'd100);
		send_request(CMD_LOAD, 4'd5, 16'd100);
		write_fit_mode(FIT_BEST);
		send_request(CMD_ALLOC, 4'd0, 16'd50);
		send_request(CMD_ALLOC, 4'd0, 16'd50);
		send_request(CMD_ALLOC, 4'd0, 16'd60);
		send_request(CMD_ALLOC, 4'd0, 16'd0);
		write_fit_mode(FIT_NEXT);
		send_request(CMD_ALLOC, 4'd0, 16'd2);
		send_request(CMD_ALLOC, 4'd0, 16'd2);
		send_request(CMD_ALLOC, 4'd0, 16'd2);
		send_request(CMD_ALLOC, 4'd0, 16'hFFFF);
		send_request(CMD_RESTORE, 4'd0, 16'd0);
		send_request(CMD_ALLOC, 4'd0, 16'd1);
		write_fit_mode(FIT_SPARE);
		send_request(CMD_ALLOC, 4'd0, 16'd1);

		write_fit_mode(FIT_FIRST);
		run_mixed(240);
		write_fit_mode(FIT_NEXT);
		run_mixed(240);
		write_fit_mode(FIT_BEST);
		run_mixed(240);
		write_fit_mode(FIT_SPARE);
		run_mixed(160);
		write_fit_mode(FIT_NEXT);
		steady = 1'b1;
		run_mixed(240);
		steady = 1'b0;
		write_fit_mode(FIT_BEST);
		run_mixed(240);
		write_fit_mode(FIT_FIRST);
		run_mixed(240);
		drain_results();

		$display("Covered %0d requests over all four fit mode codes: %0d grants, %0d refusals.",
			sb.requests, sb.grants, sb.refusals);
		if (sb.errors == 0)
			$display("tb_partition_fit_allocator: clean");
		else
			$display("tb_partition_fit_allocator: errors");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("tb_partition_fit_allocator: errors");
		$finish;
	end

endmodule
